// ===== rtl/tws_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the two-wire sensor serial master.
// Beat structs, configuration set, register indexes and sequencer phases. No dependencies.
package tws_pkg;

  typedef enum logic [1:0] {
    CFG_HALF_PERIOD   = 2'd0,
    CFG_HANDOFF       = 2'd1,
    CFG_READ_RECOVERY = 2'd2,
    CFG_WRITE_GAP     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_WDATA = 3'd2,
    PH_WGAP  = 3'd3,
    PH_HAND  = 3'd4,
    PH_RDATA = 3'd5,
    PH_RREC  = 3'd6
  } phase_e;

  localparam int unsigned CfgWidth = 16;

  typedef struct packed {
    logic [7:0]  half_period_ticks;
    logic [15:0] handoff_ticks;
    logic [15:0] read_recovery_ticks;
    logic [15:0] write_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic       start_req;
    logic       opcode;
    logic [6:0] reg_addr;
    logic [7:0] write_data;
    logic       sdio_in;
  } in_beat_t;

  typedef struct packed {
    logic       sclk;
    logic       sdio_out;
    logic       sdio_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } out_beat_t;

endpackage

// ===== rtl/tws_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register bank for the serial master.
// Depends on tws_pkg.
module tws_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  tws_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [tws_pkg::CfgWidth-1:0]  cfg_wdata_i,
  output tws_pkg::cfg_t                 cfg_o
);

  tws_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tws_pkg::CFG_HALF_PERIOD:   cfg_d.half_period_ticks   = cfg_wdata_i[7:0];
        tws_pkg::CFG_HANDOFF:       cfg_d.handoff_ticks       = cfg_wdata_i;
        tws_pkg::CFG_READ_RECOVERY: cfg_d.read_recovery_ticks = cfg_wdata_i;
        tws_pkg::CFG_WRITE_GAP:     cfg_d.write_gap_ticks     = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks   <= 8'd1;
      cfg_q.handoff_ticks       <= 16'd200;
      cfg_q.read_recovery_ticks <= 16'd200;
      cfg_q.write_gap_ticks     <= 16'd100;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/tws_core.sv =====
`timescale 1ns / 1ps
// Pin sequencer: state registers plus one tick of next-state and pin logic.
// Depends on tws_pkg.
module tws_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  tws_pkg::cfg_t      cfg_i,
  input  tws_pkg::in_beat_t  in_beat_i,
  output tws_pkg::out_beat_t res_o
);

  tws_pkg::phase_e phase_q, phase_d;
  logic [3:0]  bit_q, bit_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  pend_q, pend_d;
  logic        wflag_q, wflag_d;
  logic        clk_lvl_q, clk_lvl_d;
  logic [7:0]  rcv_q, rcv_d;

  tws_pkg::phase_e ph;
  tws_pkg::phase_e target;
  logic        do_enter;
  logic        done;
  logic [7:0]  hp;
  logic [15:0] tick_inc;
  logic [15:0] limit;
  logic [3:0]  bit_inc;

  always_comb begin
    case (phase_q)
      tws_pkg::PH_ADDR, tws_pkg::PH_WDATA, tws_pkg::PH_WGAP, tws_pkg::PH_HAND,
      tws_pkg::PH_RDATA, tws_pkg::PH_RREC: ph = phase_q;
      default: ph = tws_pkg::PH_IDLE;
    endcase

    bit_d     = bit_q;
    tick_d    = tick_q;
    shift_d   = shift_q;
    pend_d    = pend_q;
    wflag_d   = wflag_q;
    clk_lvl_d = clk_lvl_q;
    rcv_d     = rcv_q;
    done      = 1'b0;
    do_enter  = 1'b0;
    target    = tws_pkg::PH_IDLE;
    limit     = 16'd0;

    if (ph == tws_pkg::PH_IDLE && in_beat_i.start_req) begin
      wflag_d   = in_beat_i.opcode;
      shift_d   = {in_beat_i.opcode, in_beat_i.reg_addr};
      pend_d    = in_beat_i.write_data;
      ph        = tws_pkg::PH_ADDR;
      bit_d     = 4'd0;
      tick_d    = 16'd0;
      clk_lvl_d = 1'b0;
    end

    res_o.sclk       = clk_lvl_d;
    res_o.busy_res   = (ph != tws_pkg::PH_IDLE);
    res_o.sdio_out   = (ph == tws_pkg::PH_ADDR || ph == tws_pkg::PH_WDATA) ? shift_d[7] : 1'b0;
    res_o.sdio_drive = !(ph == tws_pkg::PH_HAND || ph == tws_pkg::PH_RDATA);

    hp       = (cfg_i.half_period_ticks == 8'd0) ? 8'd1 : cfg_i.half_period_ticks;
    tick_inc = tick_d + 16'd1;
    bit_inc  = bit_d + 4'd1;

    case (ph)
      tws_pkg::PH_ADDR, tws_pkg::PH_WDATA, tws_pkg::PH_RDATA: begin
        if (tick_inc < {8'd0, hp}) begin
          tick_d = tick_inc;
        end else begin
          tick_d = 16'd0;
          if (!clk_lvl_d) begin
            clk_lvl_d = 1'b1;
          end else begin
            shift_d = {shift_d[6:0], (ph == tws_pkg::PH_RDATA) ? in_beat_i.sdio_in : 1'b0};
            if (bit_d >= 4'd7) begin
              do_enter = 1'b1;
              if (ph == tws_pkg::PH_ADDR) begin
                target = wflag_d ? tws_pkg::PH_WDATA : tws_pkg::PH_HAND;
              end else if (ph == tws_pkg::PH_WDATA) begin
                target = tws_pkg::PH_WGAP;
              end else begin
                target = tws_pkg::PH_RREC;
              end
            end else begin
              bit_d     = bit_inc;
              clk_lvl_d = 1'b0;
            end
          end
        end
      end
      tws_pkg::PH_WGAP, tws_pkg::PH_HAND, tws_pkg::PH_RREC: begin
        case (ph)
          tws_pkg::PH_WGAP: limit = cfg_i.write_gap_ticks;
          tws_pkg::PH_HAND: limit = cfg_i.handoff_ticks;
          default:          limit = cfg_i.read_recovery_ticks;
        endcase
        if (tick_inc >= limit) begin
          do_enter = 1'b1;
          target   = (ph == tws_pkg::PH_HAND) ? tws_pkg::PH_RDATA : tws_pkg::PH_IDLE;
        end else begin
          tick_d = tick_inc;
        end
      end
      default: ;
    endcase

    // zero-length waits fall through to the following phase
    if (target == tws_pkg::PH_HAND && cfg_i.handoff_ticks == 16'd0) begin
      target = tws_pkg::PH_RDATA;
    end
    if ((target == tws_pkg::PH_WGAP && cfg_i.write_gap_ticks == 16'd0) ||
        (target == tws_pkg::PH_RREC && cfg_i.read_recovery_ticks == 16'd0)) begin
      target = tws_pkg::PH_IDLE;
    end

    if (do_enter) begin
      ph     = target;
      tick_d = 16'd0;
      bit_d  = 4'd0;
      case (target)
        tws_pkg::PH_WDATA: begin
          shift_d   = pend_d;
          clk_lvl_d = 1'b0;
        end
        tws_pkg::PH_RDATA: begin
          shift_d   = 8'd0;
          clk_lvl_d = 1'b0;
        end
        tws_pkg::PH_IDLE: begin
          done = 1'b1;
          if (!wflag_d) begin
            rcv_d = shift_d;
          end
        end
        default: ;
      endcase
    end

    phase_d        = ph;
    res_o.done_res  = done;
    res_o.read_data = rcv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tws_pkg::PH_IDLE;
      bit_q     <= 4'd0;
      tick_q    <= 16'd0;
      shift_q   <= 8'd0;
      pend_q    <= 8'd0;
      wflag_q   <= 1'b0;
      clk_lvl_q <= 1'b0;
      rcv_q     <= 8'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bit_q     <= bit_d;
      tick_q    <= tick_d;
      shift_q   <= shift_d;
      pend_q    <= pend_d;
      wflag_q   <= wflag_d;
      clk_lvl_q <= clk_lvl_d;
      rcv_q     <= rcv_d;
    end
  end

endmodule

// ===== rtl/tws_skid.sv =====
`timescale 1ns / 1ps
// Output register with one skid entry; stall toward the source is registered.
// Depends on tws_pkg.
module tws_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tws_pkg::out_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tws_pkg::out_beat_t  out_beat_o
);

  logic               out_valid_q, out_valid_d;
  logic               skid_full_q, skid_full_d;
  tws_pkg::out_beat_t out_q, out_d;
  tws_pkg::out_beat_t skid_q, skid_d;
  logic               accept;

  assign in_stall_o = skid_full_q;
  assign accept     = in_valid_i && !skid_full_q;

  always_comb begin
    out_valid_d = out_valid_q;
    skid_full_d = skid_full_q;
    out_d       = out_q;
    skid_d      = skid_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_full_q) begin
        out_d       = skid_q;
        out_valid_d = 1'b1;
        skid_full_d = 1'b0;
      end else begin
        out_d       = in_beat_i;
        out_valid_d = accept;
      end
    end else if (accept) begin
      skid_d      = in_beat_i;
      skid_full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

// ===== rtl/two_wire_sensor_serial_master.sv =====
`timescale 1ns / 1ps
// Two-wire half-duplex serial master for a sensor register port.
// Top level; uses tws_pkg, tws_cfg, tws_core and tws_skid.
//
// Each input beat is one sequencer tick carrying an optional read/write
// request and the sampled data pin; each accepted beat yields exactly one
// output beat with the pin levels, busy/done flags and the last read byte.
// Throughput: one beat per cycle while in_stall_o is low. The tick's logic
// runs between the state registers and the output register, so each result
// is registered there, or in the skid entry while the receiver stalls.
// The output side has an output register plus one skid entry: the input is
// taken while a result waits, and in_stall_o rises only once the skid entry
// is full, i.e. after a beat has been taken while the receiver stalled.
// Reset puts the sequencer idle with sclk low, clears the output side and
// loads default timing (half period 1, handoff 200, recovery 200, gap 100).
// Configuration writes take effect at the next edge; change them only idle.
module two_wire_sensor_serial_master (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  tws_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [tws_pkg::CfgWidth-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tws_pkg::in_beat_t             in_beat_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tws_pkg::out_beat_t            out_beat_o
);

  tws_pkg::cfg_t      cfg;
  tws_pkg::out_beat_t res;
  logic               step;

  assign step = in_valid_i && !in_stall_o;

  tws_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tws_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .cfg_i     (cfg),
    .in_beat_i (in_beat_i),
    .res_o     (res)
  );

  tws_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for two_wire_sensor_serial_master: drives sequencer ticks with requests
// and pin samples, predicts every pin beat with its own sequencer model.
// Depends on tws_pkg and the RTL top level only.
module testbench;

  localparam int unsigned CycleLimit = 200_000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  tws_pkg::cfg_idx_e            cfg_idx_i = tws_pkg::CFG_HALF_PERIOD;
  logic [tws_pkg::CfgWidth-1:0] cfg_wdata_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  tws_pkg::in_beat_t            in_beat_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  tws_pkg::out_beat_t           out_beat_o;

  two_wire_sensor_serial_master dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  always #5 clk_i = ~clk_i;

  // sequencer model state
  tws_pkg::cfg_t      timing;
  tws_pkg::phase_e    seq_ph;
  logic [3:0]         seq_bit;
  logic [15:0]        seq_cnt;
  logic [7:0]         seq_shift;
  logic [7:0]         seq_pend;
  logic               seq_wr;
  logic               seq_sclk;
  logic [7:0]         seq_rx;
  logic               seq_done;

  tws_pkg::out_beat_t pin_q[$];
  int unsigned        err_cnt = 0;
  int unsigned        cycle_cnt = 0;
  bit                 idling = 1'b1;
  int unsigned        stall_left = 0;

  function automatic void seq_enter(tws_pkg::phase_e p);
    tws_pkg::phase_e nxt;
    bit              stop;
    nxt = p;
    stop = 1'b0;
    while (!stop) begin
      seq_ph = nxt;
      seq_cnt = '0;
      seq_bit = '0;
      stop = 1'b1;
      case (nxt)
        tws_pkg::PH_WDATA: begin
          seq_shift = seq_pend;
          seq_sclk = 1'b0;
        end
        tws_pkg::PH_RDATA: begin
          seq_shift = '0;
          seq_sclk = 1'b0;
        end
        tws_pkg::PH_IDLE: begin
          seq_done = 1'b1;
          if (!seq_wr) seq_rx = seq_shift;
        end
        tws_pkg::PH_WGAP: if (timing.write_gap_ticks == 16'd0) begin
          nxt = tws_pkg::PH_IDLE;
          stop = 1'b0;
        end
        tws_pkg::PH_HAND: if (timing.handoff_ticks == 16'd0) begin
          nxt = tws_pkg::PH_RDATA;
          stop = 1'b0;
        end
        tws_pkg::PH_RREC: if (timing.read_recovery_ticks == 16'd0) begin
          nxt = tws_pkg::PH_IDLE;
          stop = 1'b0;
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void seq_advance(logic din);
    logic [15:0] hp;
    logic [15:0] lim;
    hp = (timing.half_period_ticks == 8'd0) ? 16'd1 : {8'd0, timing.half_period_ticks};
    if (seq_ph == tws_pkg::PH_ADDR || seq_ph == tws_pkg::PH_WDATA ||
        seq_ph == tws_pkg::PH_RDATA) begin
      seq_cnt = seq_cnt + 16'd1;
      if (seq_cnt < hp) return;
      seq_cnt = '0;
      if (!seq_sclk) begin
        seq_sclk = 1'b1;
        return;
      end
      seq_shift = (seq_ph == tws_pkg::PH_RDATA) ? {seq_shift[6:0], din} :
                                                  {seq_shift[6:0], 1'b0};
      seq_bit = seq_bit + 4'd1;
      if (seq_bit >= 4'd8) begin
        if (seq_ph == tws_pkg::PH_ADDR) begin
          seq_enter(seq_wr ? tws_pkg::PH_WDATA : tws_pkg::PH_HAND);
        end else if (seq_ph == tws_pkg::PH_WDATA) begin
          seq_enter(tws_pkg::PH_WGAP);
        end else begin
          seq_enter(tws_pkg::PH_RREC);
        end
      end else begin
        seq_sclk = 1'b0;
      end
      return;
    end
    case (seq_ph)
      tws_pkg::PH_WGAP: lim = timing.write_gap_ticks;
      tws_pkg::PH_HAND: lim = timing.handoff_ticks;
      tws_pkg::PH_RREC: lim = timing.read_recovery_ticks;
      default: return;
    endcase
    seq_cnt = seq_cnt + 16'd1;
    if (seq_cnt >= lim) begin
      seq_enter(seq_ph == tws_pkg::PH_HAND ? tws_pkg::PH_RDATA : tws_pkg::PH_IDLE);
    end
  endfunction

  function automatic tws_pkg::out_beat_t predict_pins(tws_pkg::in_beat_t b);
    tws_pkg::out_beat_t r;
    seq_done = 1'b0;
    if (seq_ph == tws_pkg::PH_IDLE && b.start_req) begin
      seq_wr = b.opcode;
      seq_shift = {b.opcode, b.reg_addr};
      seq_pend = b.write_data;
      seq_ph = tws_pkg::PH_ADDR;
      seq_bit = '0;
      seq_cnt = '0;
      seq_sclk = 1'b0;
    end
    r.sclk = seq_sclk;
    r.sdio_out = 1'b0;
    r.sdio_drive = 1'b1;
    r.busy_res = 1'b1;
    if (seq_ph == tws_pkg::PH_IDLE) begin
      r.busy_res = 1'b0;
    end else if (seq_ph == tws_pkg::PH_ADDR || seq_ph == tws_pkg::PH_WDATA) begin
      r.sdio_out = seq_shift[7];
    end else if (seq_ph == tws_pkg::PH_HAND || seq_ph == tws_pkg::PH_RDATA) begin
      r.sdio_drive = 1'b0;
    end
    if (seq_ph != tws_pkg::PH_IDLE) seq_advance(b.sdio_in);
    r.done_res = seq_done;
    r.read_data = seq_rx;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want != got) begin
      err_cnt++;
      if (err_cnt <= 200) $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    tws_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pin_q.size() == 0) begin
        err_cnt++;
        $error("output beat with nothing expected");
      end else begin
        want = pin_q.pop_front();
        check_field("sclk", {7'd0, want.sclk}, {7'd0, out_beat_o.sclk});
        check_field("sdio_out", {7'd0, want.sdio_out}, {7'd0, out_beat_o.sdio_out});
        check_field("sdio_drive", {7'd0, want.sdio_drive}, {7'd0, out_beat_o.sdio_drive});
        check_field("busy_res", {7'd0, want.busy_res}, {7'd0, out_beat_o.busy_res});
        check_field("done_res", {7'd0, want.done_res}, {7'd0, out_beat_o.done_res});
        check_field("read_data", want.read_data, out_beat_o.read_data);
      end
    end
  end

  // receiver stall bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) stall_left--;
    else if (idling && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 17);
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_beat(tws_pkg::in_beat_t b);
    int unsigned gap;
    if (idling && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pin_q.push_back(predict_pins(b));
  endtask

  // din_mode: 0 random pin, 1 pin low, 2 pin high
  function automatic tws_pkg::in_beat_t noise_beat(int din_mode);
    tws_pkg::in_beat_t b;
    b.start_req = ($urandom_range(0, 3) == 0);
    b.opcode = 1'($urandom_range(0, 1));
    b.reg_addr = 7'($urandom_range(0, 127));
    b.write_data = 8'($urandom_range(0, 255));
    b.sdio_in = (din_mode == 0) ? 1'($urandom_range(0, 1)) : (din_mode == 2);
    return b;
  endfunction

  task automatic idle_ticks(int unsigned n);
    tws_pkg::in_beat_t b;
    repeat (n) begin
      b = noise_beat(0);
      b.start_req = 1'b0;
      send_beat(b);
    end
  endtask

  task automatic start_txn(logic op, logic [6:0] addr, logic [7:0] data, int din_mode);
    tws_pkg::in_beat_t b;
    while (seq_ph != tws_pkg::PH_IDLE) send_beat(noise_beat(din_mode));
    b = noise_beat(din_mode);
    b.start_req = 1'b1;
    b.opcode = op;
    b.reg_addr = addr;
    b.write_data = data;
    send_beat(b);
  endtask

  task automatic run_txn(logic op, logic [6:0] addr, logic [7:0] data, int din_mode);
    start_txn(op, addr, data, din_mode);
    while (seq_ph != tws_pkg::PH_IDLE) send_beat(noise_beat(din_mode));
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pin_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(tws_pkg::cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      tws_pkg::CFG_HALF_PERIOD:   timing.half_period_ticks = val[7:0];
      tws_pkg::CFG_HANDOFF:       timing.handoff_ticks = val;
      tws_pkg::CFG_READ_RECOVERY: timing.read_recovery_ticks = val;
      tws_pkg::CFG_WRITE_GAP:     timing.write_gap_ticks = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_timing(logic [7:0] hp, logic [15:0] hand, logic [15:0] rec,
                                logic [15:0] gap);
    drain();
    cfg_write(tws_pkg::CFG_HALF_PERIOD, {8'd0, hp});
    cfg_write(tws_pkg::CFG_HANDOFF, hand);
    cfg_write(tws_pkg::CFG_READ_RECOVERY, rec);
    cfg_write(tws_pkg::CFG_WRITE_GAP, gap);
  endtask

  task automatic test_reset_timing;
    run_txn(1'b1, 7'h7F, 8'hFF, 0);
    idle_ticks(2);
  endtask

  task automatic test_zero_timing;
    program_timing(8'd0, 16'd0, 16'd0, 16'd0);
    run_txn(1'b1, 7'h00, 8'h00, 0);
    run_txn(1'b0, 7'h7F, 8'hFF, 1);
    run_txn(1'b0, 7'h2A, 8'h00, 2);
    program_timing(8'd1, 16'd1, 16'd1, 16'd1);
    run_txn(1'b0, 7'h33, 8'h5A, 0);
    idle_ticks(3);
  endtask

  task automatic test_slow_clock;
    program_timing(8'd3, 16'd0, 16'd3, 16'd0);
    run_txn(1'b0, 7'h6D, 8'hC3, 0);
  endtask

  // timing limits lowered while a wait is in progress
  task automatic test_wait_retune;
    program_timing(8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    start_txn(1'b0, 7'h19, 8'h00, 0);
    while (!(seq_ph == tws_pkg::PH_HAND && seq_cnt == 16'd12)) send_beat(noise_beat(0));
    drain();
    cfg_write(tws_pkg::CFG_HANDOFF, 16'd7);
    while (!(seq_ph == tws_pkg::PH_RREC && seq_cnt == 16'd8)) send_beat(noise_beat(0));
    drain();
    cfg_write(tws_pkg::CFG_READ_RECOVERY, 16'd8);
    while (seq_ph != tws_pkg::PH_IDLE) send_beat(noise_beat(0));
    start_txn(1'b1, 7'h62, 8'h81, 0);
    while (!(seq_ph == tws_pkg::PH_WGAP && seq_cnt == 16'd4)) send_beat(noise_beat(0));
    drain();
    cfg_write(tws_pkg::CFG_WRITE_GAP, 16'd0);
    while (seq_ph != tws_pkg::PH_IDLE) send_beat(noise_beat(0));
  endtask

  task automatic test_random_traffic;
    logic [7:0] hp;
    int         din_mode;
    for (int k = 0; k < 3; k++) begin
      hp = 8'($urandom_range(0, 2));
      program_timing(hp, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                     16'($urandom_range(0, 3)));
      idling = (k != 2);
      for (int t = 0; t < 2; t++) begin
        din_mode = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 2)) : 0;
        run_txn(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                8'($urandom_range(0, 255)), din_mode);
        idle_ticks($urandom_range(0, 2));
      end
    end
  endtask

  initial begin
    timing = '{half_period_ticks: 8'd1, handoff_ticks: 16'd200,
               read_recovery_ticks: 16'd200, write_gap_ticks: 16'd100};
    seq_ph = tws_pkg::PH_IDLE;
    seq_bit = '0;
    seq_cnt = '0;
    seq_shift = '0;
    seq_pend = '0;
    seq_wr = 1'b0;
    seq_sclk = 1'b0;
    seq_rx = '0;
    seq_done = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_timing();
    test_zero_timing();
    test_slow_clock();
    test_wait_retune();
    test_random_traffic();
    drain();
    repeat (5) @(posedge clk_i);
    if (err_cnt == 0 && pin_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
